// ----- design/ctpd_pkg.sv -----
package ctpd_pkg;

    localparam int COORD_WIDTH = 12;
    localparam int THRESH_WIDTH = 8;
    localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(10);

    typedef struct packed {
        logic [COORD_WIDTH-1:0] point_x;
        logic [COORD_WIDTH-1:0] point_y;
        logic                   curve_start;
    } point_t;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] extreme_x;
        logic [COORD_WIDTH-1:0] extreme_y;
        logic                   is_maximum;
    } extreme_t;

endpackage

// ----- design/curve_turning_point_detector_core.sv -----
// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    point_t   (point_x, point_y, curve_start)
// m_        out        m_valid/m_ready    extreme_t (extreme_x, extreme_y, is_maximum)
// cfg_      in         cfg_valid/cfg_ready cfg_data  (turn_threshold)
//
// one item per cycle while s_ready is high; a turning point reaches m_ from a registered queue entry
// tracking state updates in the accept cycle, the result lands in a two-entry output queue
// s_ready drops only while both queue entries are full; cfg_ready is always high
// synchronous active-low reset: threshold 10, tracking cleared, queue empty
module curve_turning_point_detector_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ctpd_pkg::point_t                  s_item,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ctpd_pkg::extreme_t                m_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ctpd_pkg::THRESH_WIDTH-1:0] cfg_data
);

    logic               pt_accept;
    logic               res_valid;
    ctpd_pkg::extreme_t res_item;
    logic               pop;
    logic               out_valid_reg, skid_valid_reg;
    ctpd_pkg::extreme_t out_reg, skid_reg;

    assign s_ready   = !skid_valid_reg;
    assign pt_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_reg;
    assign pop       = out_valid_reg && m_ready;

    ctpd_tracker u_tracker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid),
        .cfg_data  (cfg_data),
        .pt_accept (pt_accept),
        .pt_item   (s_item),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (!out_valid_reg || pop) begin
            out_valid_reg <= res_valid;
            if (res_valid) begin
                out_reg <= res_item;
            end
        end else if (res_valid) begin
            skid_reg       <= res_item;
            skid_valid_reg <= 1'b1;
        end
    end

endmodule

// ----- design/ctpd_tracker.sv -----
module ctpd_tracker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_write,
    input  logic [ctpd_pkg::THRESH_WIDTH-1:0] cfg_data,
    input  logic                            pt_accept,
    input  ctpd_pkg::point_t                pt_item,
    output logic                            res_valid,
    output ctpd_pkg::extreme_t              res_item
);

    typedef enum logic [1:0] {
        DIR_UNDECIDED = 2'd0,
        DIR_RISING    = 2'd1,
        DIR_FALLING   = 2'd2
    } dir_t;

    logic [ctpd_pkg::THRESH_WIDTH-1:0] thresh_reg;
    dir_t                              dir_reg, dir_next;
    logic [ctpd_pkg::THRESH_WIDTH-1:0] run_reg, run_next;
    logic [ctpd_pkg::COORD_WIDTH-1:0]  prev_x_reg, prev_x_next;
    logic [ctpd_pkg::COORD_WIDTH-1:0]  min_x_reg, min_x_next, min_y_reg, min_y_next;
    logic [ctpd_pkg::COORD_WIDTH-1:0]  max_x_reg, max_x_next, max_y_reg, max_y_next;
    logic                              flip;
    logic [ctpd_pkg::THRESH_WIDTH-1:0] run_counted;
    logic                              step_right, step_left;

    // flip test comes before counting
    assign flip        = (run_reg >= thresh_reg);
    assign run_counted = flip ? '0 : run_reg + 1'b1;
    assign step_right  = (pt_item.point_x > prev_x_reg);
    assign step_left   = (pt_item.point_x < prev_x_reg);

    always_comb begin
        dir_next    = dir_reg;
        run_next    = run_reg;
        prev_x_next = prev_x_reg;
        min_x_next  = min_x_reg;
        min_y_next  = min_y_reg;
        max_x_next  = max_x_reg;
        max_y_next  = max_y_reg;
        res_valid   = 1'b0;
        res_item    = '0;
        if (pt_accept) begin
            prev_x_next = pt_item.point_x;
            if (pt_item.curve_start) begin
                dir_next   = DIR_UNDECIDED;
                run_next   = '0;
                min_x_next = '0;
                min_y_next = '0;
                max_x_next = '0;
                max_y_next = '0;
            end else if (step_right) begin
                case (dir_reg)
                    DIR_RISING: begin
                        run_next   = '0;
                        max_x_next = pt_item.point_x;
                        max_y_next = pt_item.point_y;
                    end
                    DIR_FALLING: begin
                        run_next = run_counted;
                        if (flip) begin
                            dir_next            = DIR_RISING;
                            res_valid           = 1'b1;
                            res_item.extreme_x  = min_x_reg;
                            res_item.extreme_y  = min_y_reg;
                            res_item.is_maximum = 1'b0;
                        end
                    end
                    default: begin
                        run_next = run_counted;
                        if (flip) begin
                            dir_next = DIR_RISING;
                        end
                    end
                endcase
            end else if (step_left) begin
                case (dir_reg)
                    DIR_FALLING: begin
                        run_next   = '0;
                        min_x_next = pt_item.point_x;
                        min_y_next = pt_item.point_y;
                    end
                    DIR_RISING: begin
                        run_next = run_counted;
                        if (flip) begin
                            dir_next            = DIR_FALLING;
                            res_valid           = 1'b1;
                            res_item.extreme_x  = max_x_reg;
                            res_item.extreme_y  = max_y_reg;
                            res_item.is_maximum = 1'b1;
                        end
                    end
                    default: begin
                        run_next = run_counted;
                        if (flip) begin
                            dir_next = DIR_FALLING;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= ctpd_pkg::THRESH_RESET;
            dir_reg    <= DIR_UNDECIDED;
            run_reg    <= '0;
            prev_x_reg <= '0;
            min_x_reg  <= '0;
            min_y_reg  <= '0;
            max_x_reg  <= '0;
            max_y_reg  <= '0;
        end else begin
            if (cfg_write) begin
                thresh_reg <= cfg_data;
            end
            dir_reg    <= dir_next;
            run_reg    <= run_next;
            prev_x_reg <= prev_x_next;
            min_x_reg  <= min_x_next;
            min_y_reg  <= min_y_next;
            max_x_reg  <= max_x_next;
            max_y_reg  <= max_y_next;
        end
    end

endmodule
